@@ rtl/core/cnms_pkg.sv @@
// Shared types and constants for the class-aware NMS block.
// No dependencies.
package cnms_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int TAG_W          = 6;
    localparam logic [15:0] IOU_THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic signed [15:0] right_x;
        logic signed [15:0] bottom_y;
        logic        [15:0] score;
        logic        [7:0]  class_index;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic             valid;
        logic             same_class;
        logic [TAG_W-1:0] tag;
    } iou_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [TAG_W-1:0] tag;
    } iou_res_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RANK_RD,
        ST_RANK_LAT,
        ST_RANK_SCAN,
        ST_RANK_LAST,
        ST_RANK_WR,
        ST_SUP_MARK,
        ST_SUP_ORD,
        ST_SUP_BOX,
        ST_SUP_SCAN,
        ST_SUP_DRAIN,
        ST_SUP_NEXT,
        ST_EMIT_ADDR,
        ST_EMIT_IDX,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } state_t;

endpackage

@@ rtl/core/cnms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnms_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/cnms_iou_unit.sv @@
// Five-stage pipelined IoU threshold test without division.
// Depends on cnms_pkg.
module cnms_iou_unit
    import cnms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iou_ctl_t    ctl,
    input  box_t        box_a,
    input  box_t        box_b,
    input  logic [15:0] thr,
    output iou_res_t    res,
    output logic        busy
);

    iou_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    iou_res_t res_reg;

    logic signed [16:0] iw1_reg, ih1_reg, wa1_reg, ha1_reg, wb1_reg, hb1_reg;
    logic        [31:0] inter2_reg, inter3_reg, inter4_reg;
    logic signed [33:0] area_a2_reg, area_b2_reg;
    logic signed [35:0] uni3_reg;
    logic               pos3_reg, pos4_reg;
    logic        [32:0] p_lo4_reg, p_hi4_reg;

    logic signed [15:0] ix1, iy1, ix2, iy2;
    logic        [15:0] iw_pos, ih_pos;
    logic signed [35:0] uni_next;
    logic        [49:0] rhs, lhs;

    always_comb
    begin
        ix1 = (box_a.left_x   > box_b.left_x)   ? box_a.left_x   : box_b.left_x;
        iy1 = (box_a.top_y    > box_b.top_y)    ? box_a.top_y    : box_b.top_y;
        ix2 = (box_a.right_x  < box_b.right_x)  ? box_a.right_x  : box_b.right_x;
        iy2 = (box_a.bottom_y < box_b.bottom_y) ? box_a.bottom_y : box_b.bottom_y;
        iw_pos = (iw1_reg > 17'sd0) ? iw1_reg[15:0] : 16'd0;
        ih_pos = (ih1_reg > 17'sd0) ? ih1_reg[15:0] : 16'd0;
        uni_next = 36'(area_a2_reg) + 36'(area_b2_reg) - $signed({4'd0, inter2_reg});
        rhs = {p_hi4_reg, 17'd0} + 50'(p_lo4_reg);
        lhs = 50'({inter4_reg, 16'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            ctl1_reg      <= ctl;
            ctl2_reg      <= ctl1_reg;
            ctl3_reg      <= ctl2_reg;
            ctl4_reg      <= ctl3_reg;
            res_reg.valid <= ctl4_reg.valid;
            res_reg.tag   <= ctl4_reg.tag;
            res_reg.hit   <= ctl4_reg.same_class && pos4_reg && (lhs > rhs);
        end
    end

    always_ff @(posedge clk)
    begin
        iw1_reg     <= 17'(ix2) - 17'(ix1);
        ih1_reg     <= 17'(iy2) - 17'(iy1);
        wa1_reg     <= 17'(box_a.right_x) - 17'(box_a.left_x);
        ha1_reg     <= 17'(box_a.bottom_y) - 17'(box_a.top_y);
        wb1_reg     <= 17'(box_b.right_x) - 17'(box_b.left_x);
        hb1_reg     <= 17'(box_b.bottom_y) - 17'(box_b.top_y);
        inter2_reg  <= iw_pos * ih_pos;
        area_a2_reg <= wa1_reg * ha1_reg;
        area_b2_reg <= wb1_reg * hb1_reg;
        uni3_reg    <= uni_next;
        pos3_reg    <= uni_next > 36'sd0;
        inter3_reg  <= inter2_reg;
        p_lo4_reg   <= thr * uni3_reg[16:0];
        p_hi4_reg   <= thr * uni3_reg[33:17];
        pos4_reg    <= pos3_reg;
        inter4_reg  <= inter3_reg;
    end

    assign res  = res_reg;
    assign busy = ctl1_reg.valid | ctl2_reg.valid | ctl3_reg.valid | ctl4_reg.valid;

endmodule

@@ rtl/core/class_aware_nms_top.sv @@
// Class-aware greedy NMS: loads a frame of boxes, ranks, suppresses, emits kept boxes.
// Loading accepts one item per cycle. After the final item, ranking makes one box
// memory read per pair, suppression scans the boxes ranked below each kept box, and
// kept boxes are then emitted subject to output stall. Intake is stalled from the final
// item until the last result transfers. Asynchronous active-low reset clears control
// state and sets the IoU threshold to 29491; box memories hold no reset value.
module class_aware_nms_top
    import cnms_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               iou_threshold_we,
    input  logic [15:0]        iou_threshold_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] left_x,
    input  logic signed [15:0] top_y,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] bottom_y,
    input  logic [15:0]        score,
    input  logic [7:0]         class_index,
    input  logic               final_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] kept_left_x,
    output logic signed [15:0] kept_top_y,
    output logic signed [15:0] kept_right_x,
    output logic signed [15:0] kept_bottom_y,
    output logic [15:0]        kept_score,
    output logic [7:0]         kept_class,
    output logic               overflowed,
    output logic               last_kept
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    state_t state_reg, state_next;

    logic [15:0]          thr_reg;
    logic [CNT_W-1:0]     cnt_reg, i_reg, j_reg, k_reg, nk_reg, rank_reg;
    logic                 ovf_reg;
    logic [MAX_BOXES-1:0] marks_reg;
    logic [15:0]          si_reg;
    logic                 sv_reg;
    logic [CNT_W-1:0]     sj_reg;
    logic [IDX_W-1:0]     a_idx_reg;
    box_t                 a_reg;
    logic                 v1_reg, v2_reg;
    logic [IDX_W-1:0]     j1_reg, j2_reg;
    logic                 out_valid_reg, last_reg, ovf_out_reg;
    box_t                 out_reg;

    logic             in_xfer, out_xfer, i_last, j_last, pipe_busy, issue_v, rank_hit;
    logic             box_we, ord_we, kept_we;
    logic [IDX_W-1:0] box_waddr, box_raddr, ord_waddr, ord_raddr, kept_raddr;
    box_t             box_wdata, box_rdata;
    logic [IDX_W-1:0] ord_rdata, kept_rdata;
    iou_ctl_t         iou_ctl;
    iou_res_t         iou_res;
    logic             iou_busy;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign i_last   = (i_reg + CNT_W'(1)) == cnt_reg;
    assign j_last   = (j_reg + CNT_W'(1)) == cnt_reg;
    assign pipe_busy = v1_reg | v2_reg | iou_busy;
    assign rank_hit = (box_rdata.score > si_reg) ||
                      ((box_rdata.score == si_reg) && (sj_reg < i_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (in_xfer && final_item) state_next = ST_RANK_RD;
            ST_RANK_RD:   state_next = ST_RANK_LAT;
            ST_RANK_LAT:  state_next = ST_RANK_SCAN;
            ST_RANK_SCAN: if (j_last) state_next = ST_RANK_LAST;
            ST_RANK_LAST: state_next = ST_RANK_WR;
            ST_RANK_WR:   state_next = i_last ? ST_SUP_MARK : ST_RANK_RD;
            ST_SUP_MARK:  state_next = marks_reg[i_reg[IDX_W-1:0]] ? ST_SUP_NEXT : ST_SUP_ORD;
            ST_SUP_ORD:   state_next = ST_SUP_BOX;
            ST_SUP_BOX:   state_next = i_last ? ST_SUP_NEXT : ST_SUP_SCAN;
            ST_SUP_SCAN:  if (j_last) state_next = ST_SUP_DRAIN;
            ST_SUP_DRAIN: if (!pipe_busy) state_next = ST_SUP_NEXT;
            ST_SUP_NEXT:  state_next = i_last ? ST_EMIT_ADDR : ST_SUP_MARK;
            ST_EMIT_ADDR: state_next = ST_EMIT_IDX;
            ST_EMIT_IDX:  state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    state_next = last_reg ? ST_LOAD : ST_EMIT_ADDR;
                end
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        box_we     = 1'b0;
        box_waddr  = cnt_reg[IDX_W-1:0];
        box_raddr  = ord_rdata;
        ord_we     = 1'b0;
        ord_waddr  = rank_reg[IDX_W-1:0];
        ord_raddr  = i_reg[IDX_W-1:0];
        kept_we    = 1'b0;
        kept_raddr = k_reg[IDX_W-1:0];
        issue_v    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                box_we   = in_valid && (cnt_reg < CNT_W'(MAX_BOXES));
            end
            ST_RANK_RD:   box_raddr = i_reg[IDX_W-1:0];
            ST_RANK_SCAN: box_raddr = j_reg[IDX_W-1:0];
            ST_RANK_WR:   ord_we = 1'b1;
            ST_SUP_BOX:   kept_we = 1'b1;
            ST_SUP_SCAN:
            begin
                ord_raddr = j_reg[IDX_W-1:0];
                issue_v   = !marks_reg[j_reg[IDX_W-1:0]];
            end
            ST_EMIT_IDX:  box_raddr = kept_rdata;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            thr_reg       <= IOU_THR_RESET;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            marks_reg     <= '0;
            sv_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sv_reg    <= (state_reg == ST_RANK_SCAN);
            v1_reg    <= issue_v;
            v2_reg    <= v1_reg;
            if (iou_threshold_we)
            begin
                thr_reg <= iou_threshold_wdata;
            end
            if (in_xfer)
            begin
                if (cnt_reg < CNT_W'(MAX_BOXES))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (iou_res.valid && iou_res.hit)
            begin
                marks_reg[iou_res.tag[IDX_W-1:0]] <= 1'b1;
            end
            if (state_reg == ST_EMIT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
                if (last_reg)
                begin
                    cnt_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    marks_reg <= '0;
                end
            end
        end
    end

    // sequencer counters and datapath registers
    always_ff @(posedge clk)
    begin
        sj_reg <= j_reg;
        j1_reg <= j_reg[IDX_W-1:0];
        j2_reg <= j1_reg;
        if (sv_reg && rank_hit)
        begin
            rank_reg <= rank_reg + CNT_W'(1);
        end
        case (state_reg)
            ST_LOAD:
            begin
                i_reg <= '0;
            end
            ST_RANK_RD:
            begin
                rank_reg <= '0;
                j_reg    <= '0;
            end
            ST_RANK_LAT:  si_reg <= box_rdata.score;
            ST_RANK_SCAN: j_reg <= j_reg + CNT_W'(1);
            ST_RANK_WR:
            begin
                i_reg  <= i_last ? '0 : i_reg + CNT_W'(1);
                nk_reg <= '0;
            end
            ST_SUP_ORD:   a_idx_reg <= ord_rdata;
            ST_SUP_BOX:
            begin
                a_reg  <= box_rdata;
                nk_reg <= nk_reg + CNT_W'(1);
                j_reg  <= i_reg + CNT_W'(1);
            end
            ST_SUP_SCAN:  j_reg <= j_reg + CNT_W'(1);
            ST_SUP_NEXT:
            begin
                i_reg <= i_reg + CNT_W'(1);
                k_reg <= '0;
            end
            ST_EMIT_LOAD:
            begin
                out_reg     <= box_rdata;
                ovf_out_reg <= ovf_reg;
                last_reg    <= (k_reg + CNT_W'(1)) == nk_reg;
            end
            ST_EMIT_WAIT: if (out_xfer) k_reg <= k_reg + CNT_W'(1);
            default:      ;
        endcase
    end

    assign box_wdata = '{left_x: left_x, top_y: top_y, right_x: right_x,
                         bottom_y: bottom_y, score: score, class_index: class_index};

    assign iou_ctl.valid      = v2_reg;
    assign iou_ctl.same_class = a_reg.class_index == box_rdata.class_index;
    assign iou_ctl.tag        = TAG_W'(j2_reg);

    cnms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .clk     (clk),
        .wr_en   (box_we),
        .wr_addr (box_waddr),
        .wr_data (box_wdata),
        .rd_addr (box_raddr),
        .rd_data (box_rdata)
    );

    cnms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_order_ram (
        .clk     (clk),
        .wr_en   (ord_we),
        .wr_addr (ord_waddr),
        .wr_data (i_reg[IDX_W-1:0]),
        .rd_addr (ord_raddr),
        .rd_data (ord_rdata)
    );

    cnms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_kept_ram (
        .clk     (clk),
        .wr_en   (kept_we),
        .wr_addr (nk_reg[IDX_W-1:0]),
        .wr_data (a_idx_reg),
        .rd_addr (kept_raddr),
        .rd_data (kept_rdata)
    );

    cnms_iou_unit u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (iou_ctl),
        .box_a (a_reg),
        .box_b (box_rdata),
        .thr   (thr_reg),
        .res   (iou_res),
        .busy  (iou_busy)
    );

    assign out_valid     = out_valid_reg;
    assign kept_left_x   = out_reg.left_x;
    assign kept_top_y    = out_reg.top_y;
    assign kept_right_x  = out_reg.right_x;
    assign kept_bottom_y = out_reg.bottom_y;
    assign kept_score    = out_reg.score;
    assign kept_class    = out_reg.class_index;
    assign overflowed    = ovf_out_reg;
    assign last_kept     = last_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BOXES))
        else $error("loaded count beyond capacity");

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_EMIT_WAIT)
        else $error("result valid outside emit");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (nk_reg != '0) && (k_reg < nk_reg))
        else $error("emit index out of kept range");

    a_iou_phase: assert property (@(posedge clk) disable iff (!rst_n)
        iou_res.valid |-> (state_reg == ST_SUP_SCAN) || (state_reg == ST_SUP_DRAIN))
        else $error("IoU result outside suppression scan");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUP_NEXT) |-> !pipe_busy)
        else $error("suppression pipeline not drained");
`endif

endmodule

@@ tb/class_aware_nms_top_tb.sv @@
// Testbench for class_aware_nms_top: drives frames of candidate boxes, predicts the kept
// boxes with a behavioral greedy per-class NMS and checks every output transfer.
// Depends on cnms_pkg and class_aware_nms_top.
`timescale 1ns / 1ps

module class_aware_nms_top_tb;
    import cnms_pkg::*;

    localparam int NBOX = MAX_BOXES_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        box_t box;
        logic last;
    } cand_t;

    typedef struct packed {
        box_t box;
        logic ovf;
        logic last;
    } kept_t;

    logic clk;
    logic rst_n;
    logic thr_we;
    logic [15:0] thr_wdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] left_x, top_y, right_x, bottom_y;
    logic [15:0] score;
    logic [7:0] class_index;
    logic final_item;
    logic signed [15:0] kept_left_x, kept_top_y, kept_right_x, kept_bottom_y;
    logic [15:0] kept_score;
    logic [7:0] kept_class;
    logic overflowed, last_kept;

    class_aware_nms_top dut (
        .clk(clk), .rst_n(rst_n),
        .iou_threshold_we(thr_we), .iou_threshold_wdata(thr_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_x(left_x), .top_y(top_y), .right_x(right_x), .bottom_y(bottom_y),
        .score(score), .class_index(class_index), .final_item(final_item),
        .out_valid(out_valid), .out_stall(out_stall),
        .kept_left_x(kept_left_x), .kept_top_y(kept_top_y),
        .kept_right_x(kept_right_x), .kept_bottom_y(kept_bottom_y),
        .kept_score(kept_score), .kept_class(kept_class),
        .overflowed(overflowed), .last_kept(last_kept)
    );

    // predictor state
    logic [15:0] thr_model;
    box_t frame_boxes[NBOX];
    int frame_count = 0;
    bit frame_ovf = 0;

    cand_t pending_q[$];
    kept_t kept_q[$];
    int mismatches = 0;
    int idle_pct, stall_pct;
    bit hold_off;
    bit done_flag;
    int quiet_cycles = 0;
    bit in_taken;

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic bit too_much_overlap(box_t a, box_t b, logic [15:0] thr);
        longint ix1, iy1, ix2, iy2, iw, ih, inter, uni;
        ix1 = (a.left_x > b.left_x) ? a.left_x : b.left_x;
        iy1 = (a.top_y > b.top_y) ? a.top_y : b.top_y;
        ix2 = (a.right_x < b.right_x) ? a.right_x : b.right_x;
        iy2 = (a.bottom_y < b.bottom_y) ? a.bottom_y : b.bottom_y;
        iw = (ix2 - ix1 > 0) ? ix2 - ix1 : 0;
        ih = (iy2 - iy1 > 0) ? iy2 - iy1 : 0;
        inter = iw * ih;
        uni = (longint'(a.right_x) - a.left_x) * (longint'(a.bottom_y) - a.top_y)
            + (longint'(b.right_x) - b.left_x) * (longint'(b.bottom_y) - b.top_y) - inter;
        if (uni <= 0)
            return 0;
        return inter * 65536 > longint'(thr) * uni;
    endfunction

    function automatic void predict_kept(cand_t c);
        int rank[NBOX];
        bit gone[NBOX];
        int j, last_i;
        kept_t k;
        if (frame_count < NBOX)
        begin
            frame_boxes[frame_count] = c.box;
            frame_count++;
        end
        else
            frame_ovf = 1;
        if (!c.last)
            return;
        for (int i = 0; i < frame_count; i++)
        begin
            j = i;
            while (j > 0 && frame_boxes[rank[j-1]].score < frame_boxes[i].score)
            begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = i;
            gone[i] = 0;
        end
        for (int i = 0; i < frame_count; i++)
        begin
            if (gone[i])
                continue;
            last_i = i;
            for (int m = i + 1; m < frame_count; m++)
                if (!gone[m] && frame_boxes[rank[i]].class_index ==
                    frame_boxes[rank[m]].class_index &&
                    too_much_overlap(frame_boxes[rank[i]], frame_boxes[rank[m]], thr_model))
                    gone[m] = 1;
        end
        for (int i = 0; i < frame_count; i++)
            if (!gone[i])
            begin
                k.box = frame_boxes[rank[i]];
                k.ovf = frame_ovf;
                k.last = (i == last_i);
                kept_q.insert(kept_q.size(), k);
            end
        frame_count = 0;
        frame_ovf = 0;
    endfunction

    // input transfer seen at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 0;
        else
            in_taken <= in_valid && !in_stall;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            {left_x, top_y, right_x, bottom_y, score, class_index, final_item} <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cand_t c;
                c = pending_q.pop_front();
                in_valid <= 1;
                left_x <= c.box.left_x;
                top_y <= c.box.top_y;
                right_x <= c.box.right_x;
                bottom_y <= c.box.bottom_y;
                score <= c.box.score;
                class_index <= c.box.class_index;
                final_item <= c.last;
            end
            else
                in_valid <= 0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
            out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && !in_stall)
            begin
                cand_t c;
                c.box = '{left_x, top_y, right_x, bottom_y, score, class_index};
                c.last = final_item;
                predict_kept(c);
            end
            if (out_valid && !out_stall)
            begin
                kept_t got, want;
                got.box = '{kept_left_x, kept_top_y, kept_right_x, kept_bottom_y,
                            kept_score, kept_class};
                got.ovf = overflowed;
                got.last = last_kept;
                if (kept_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected kept box %h", got);
                end
                else
                begin
                    want = kept_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("kept box mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (quiet_cycles > WATCHDOG_LIMIT)
            begin
                $display("class_aware_nms_top_tb failed");
                $finish;
            end
        end
    end

    function automatic box_t rand_box(int cls_span);
        box_t b;
        int x, y;
        x = $urandom_range(400);
        y = $urandom_range(400);
        b.left_x = 16'(x);
        b.top_y = 16'(y);
        b.right_x = 16'(x + int'($urandom_range(200)));
        b.bottom_y = 16'(y + int'($urandom_range(200)));
        b.score = 16'($urandom);
        b.class_index = 8'($urandom_range(cls_span));
        if ($urandom_range(15) == 0)
        begin
            b.left_x = 16'($urandom);
            b.top_y = 16'($urandom);
            b.right_x = 16'($urandom);
            b.bottom_y = 16'($urandom);
            b.class_index = 8'($urandom);
        end
        if ($urandom_range(7) == 0)
            b.score = 16'($urandom_range(3));
        return b;
    endfunction

    task automatic queue_frame(int n, int cls_span);
        cand_t c;
        for (int i = 0; i < n; i++)
        begin
            c.box = rand_box(cls_span);
            c.last = (i == n - 1);
            pending_q.insert(pending_q.size(), c);
        end
    endtask

    task automatic drain_and_set(logic [15:0] thr);
        while (pending_q.size() > 0 || kept_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        thr_we <= 1;
        thr_wdata <= thr;
        @(negedge clk);
        thr_we <= 0;
        thr_model = thr;
    endtask

    initial
    begin
        cand_t c;
        rst_n = 0;
        thr_we = 0;
        thr_wdata = 0;
        thr_model = IOU_THR_RESET;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, identical boxes, ties, reversed and degenerate boxes
        c.last = 0;
        c.box = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 8'hff};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 8'hff};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'h0000, 8'h00};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sd10, 16'sd10, 16'sd10, 16'sd50, 16'h1000, 8'h00};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h1000, 8'h01};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sd5, 16'sd5, 16'sd100, 16'sd100, 16'h1000, 8'h01};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h0800, 8'h02};
        pending_q.insert(pending_q.size(), c);
        c.last = 1;
        c.box = '{16'sd90, 16'sd0, 16'sd200, 16'sd100, 16'h0800, 8'h01};
        pending_q.insert(pending_q.size(), c);
        c.box = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'h5555, 8'haa};
        pending_q.insert(pending_q.size(), c);
        queue_frame(NBOX + 3, 3);

        drain_and_set(16'd0);
        queue_frame(6, 1);
        drain_and_set(16'hffff);
        queue_frame(6, 1);
        drain_and_set(16'd16384);

        // long receiver hold-off with the input kept busy
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
        join_none
        for (int f = 0; f < 6; f++)
            queue_frame($urandom_range(1, 4), 2);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_and_set(ph == 2 ? IOU_THR_RESET : 16'($urandom));
            idle_pct = (ph == 1) ? 58 : 0;
            stall_pct = (ph == 3) ? 58 : 0;
            if (ph == 2)
            begin
                idle_pct = 11;
                stall_pct = 11;
            end
            for (int f = 0; f < 6; f++)
                queue_frame($urandom_range(1, 6), $urandom_range(0, 3));
        end

        while (pending_q.size() > 0 || kept_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && kept_q.size() == 0)
            $display("class_aware_nms_top_tb passed");
        else
            $display("class_aware_nms_top_tb failed");
        $finish;
    end

endmodule

@@ class_aware_nms_top.f @@
rtl/core/cnms_pkg.sv
rtl/core/cnms_ram.sv
rtl/core/cnms_iou_unit.sv
rtl/core/class_aware_nms_top.sv
tb/class_aware_nms_top_tb.sv
